@@ src/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled while the active-low reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("concurrent assertion failed");

// same check with the reset left active, for properties that hold in reset too
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("concurrent assertion failed");

`endif

@@ src/egcd_pkg.sv @@
// shared types and constants for the euclid gcd engine
package egcd_pkg;

    localparam int unsigned OPERAND_BITS = 32;
    localparam int unsigned RESULT_BITS  = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

endpackage

@@ src/egcd_rem_unit.sv @@
// shift-subtract remainder unit, one quotient bit per cycle
module egcd_rem_unit #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [WIDTH-1:0] r_dvd;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;

    // bring down the next dividend bit and try one subtract
    always_comb begin
        w_trial = {r_rem, r_dvd[WIDTH-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (w_diff[WIDTH]) begin
            n_rem = w_trial[WIDTH-1:0];
        end else begin
            n_rem = w_diff[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(WIDTH);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

@@ src/euclid_gcd_engine.sv @@
// euclid gcd engine: one request of two operands in, their gcd out
// a zero operand skips the division: the request goes from idle straight to the finish state
// else k euclid steps, at most about 1.44*WIDTH; each is a load state and one pass of the remainder unit
// one request at a time: the next request is taken once the result sits in the output register
// a held result only stalls the next request in its finish state
// reset: synchronous, active low; clears the sequencer and the output valid
module euclid_gcd_engine #(
    parameter int unsigned WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] operand_a, [63:32] operand_b
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] divisor
    output logic        o_m_tuser    // [0] both_zero
);

    egcd_pkg::t_state r_state;
    egcd_pkg::t_state n_state;

    logic [WIDTH-1:0] r_big;
    logic [WIDTH-1:0] n_big;
    logic [WIDTH-1:0] r_small;
    logic [WIDTH-1:0] n_small;
    logic             r_zero;
    logic             n_zero;

    logic             r_out_valid;
    logic             n_out_valid;
    logic [egcd_pkg::RESULT_BITS-1:0] r_out_div;
    logic [egcd_pkg::RESULT_BITS-1:0] n_out_div;
    logic             r_out_zero;
    logic             n_out_zero;

    logic [WIDTH-1:0] w_a;
    logic [WIDTH-1:0] w_b;
    logic [egcd_pkg::RESULT_BITS-1:0] w_small_out;

    logic             w_rem_start;
    logic             w_rem_done;
    logic [WIDTH-1:0] w_rem;
    logic             w_accept;

    // operands are taken modulo 2^WIDTH; result is zero-extended or cut to the port width
    generate
        if (WIDTH > egcd_pkg::OPERAND_BITS) begin : g_wide
            assign w_a = {{(WIDTH-32){1'b0}}, i_s_tdata[31:0]};
            assign w_b = {{(WIDTH-32){1'b0}}, i_s_tdata[63:32]};
            assign w_small_out = r_small[31:0];
        end else if (WIDTH == egcd_pkg::OPERAND_BITS) begin : g_equal
            assign w_a = i_s_tdata[31:0];
            assign w_b = i_s_tdata[63:32];
            assign w_small_out = r_small;
        end else begin : g_narrow
            assign w_a = i_s_tdata[WIDTH-1:0];
            assign w_b = i_s_tdata[WIDTH+31:32];
            assign w_small_out = {{(32-WIDTH){1'b0}}, r_small};
        end
    endgenerate

    assign w_accept = i_s_tvalid && o_s_tready;

    egcd_rem_unit #(
        .WIDTH(WIDTH)
    ) u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_rem_start),
        .i_dividend  (r_big),
        .i_divisor   (r_small),
        .o_done      (w_rem_done),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= egcd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_big      <= n_big;
        r_small    <= n_small;
        r_zero     <= n_zero;
        r_out_div  <= n_out_div;
        r_out_zero <= n_out_zero;
    end

    always_comb begin
        n_state     = r_state;
        n_big       = r_big;
        n_small     = r_small;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;
        n_out_div   = r_out_div;
        n_out_zero  = r_out_zero;
        o_s_tready  = 1'b0;
        w_rem_start = 1'b0;

        // result taken downstream frees the output register
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            egcd_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (w_accept) begin
                    if ((w_a == '0) || (w_b == '0)) begin
                        // a zero operand: gcd is the other one, flag when both are zero
                        n_small = w_a | w_b;
                        n_zero  = (w_a | w_b) == '0;
                        n_state = egcd_pkg::ST_FINISH;
                    end else begin
                        // order the pair so the larger is divided first
                        n_zero = 1'b0;
                        if (w_a >= w_b) begin
                            n_big   = w_a;
                            n_small = w_b;
                        end else begin
                            n_big   = w_b;
                            n_small = w_a;
                        end
                        n_state = egcd_pkg::ST_LOAD;
                    end
                end
            end
            egcd_pkg::ST_LOAD: begin
                // kick one remainder pass of big mod small
                w_rem_start = 1'b1;
                n_state     = egcd_pkg::ST_DIVIDE;
            end
            egcd_pkg::ST_DIVIDE: begin
                if (w_rem_done) begin
                    if (w_rem == '0) begin
                        // small divides evenly: it is the gcd
                        n_state = egcd_pkg::ST_FINISH;
                    end else begin
                        n_big   = r_small;
                        n_small = w_rem;
                        n_state = egcd_pkg::ST_LOAD;
                    end
                end
            end
            egcd_pkg::ST_FINISH: begin
                // wait for room in the output register
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_div   = w_small_out;
                    n_out_zero  = r_zero;
                    n_state     = egcd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = egcd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_div;
    assign o_m_tuser  = r_out_zero;

endmodule

@@ src/egcd_checker.sv @@
// port-level checker for the euclid gcd engine and its bind
`include "assert_macros.svh"

module egcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [63:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser
);

    logic w_in_fire;
    logic w_out_stall;

    assign w_in_fire   = i_s_tvalid && o_s_tready && (i_s_tdata == i_s_tdata);
    assign w_out_stall = o_m_tvalid && !i_m_tready;

    // a stalled result stays offered
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, w_out_stall |=> o_m_tvalid)

    // a stalled result keeps its payload
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, w_out_stall |=> ($stable(o_m_tdata) && $stable(o_m_tuser)))

    // one request at a time: ready drops right after a request is taken
    `ASSERT_CLK(a_one_at_a_time, i_clk, i_rst_n, w_in_fire |=> !o_s_tready)

    // the both-zero flag only comes with a zero divisor
    `ASSERT_CLK(a_zero_flag, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 32'd0))

endmodule

bind euclid_gcd_engine egcd_checker u_egcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

@@ dv/euclid_gcd_engine_tb.sv @@
// self-checking testbench for the euclid gcd engine: random and directed operand pairs
module euclid_gcd_engine_tb;

    localparam int unsigned CYCLE_LIMIT  = 8_000_000;
    localparam int unsigned RANDOM_ITEMS = 1030;
    localparam int unsigned TAIL_ITEMS   = 120;   // last requests run with no idling
    localparam int unsigned DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [egcd_pkg::OPERAND_BITS-1:0] operand_b;
        logic [egcd_pkg::OPERAND_BITS-1:0] operand_a;
    } t_gcd_request;

    typedef struct packed {
        logic                             both_zero;
        logic [egcd_pkg::RESULT_BITS-1:0] divisor;
    } t_gcd_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata  = '0;   // [31:0] operand_a, [63:32] operand_b
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // [31:0] divisor
    logic        o_m_tuser;         // [0] both_zero

    euclid_gcd_engine #(.WIDTH(egcd_pkg::OPERAND_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    t_gcd_request   request_queue[$];
    t_gcd_result    gcd_due[$];
    t_gcd_result    due_head;
    int unsigned    fail_count = 0;
    int unsigned    cycle_count = 0;
    logic           req_fired = 1'b0;
    int unsigned    src_idle = 0;
    logic           src_rested = 1'b0;
    int unsigned    sink_hold = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // euclid by remainders, zero operands handled up front
    function automatic t_gcd_result expected_gcd(input logic [egcd_pkg::OPERAND_BITS-1:0] a,
                                                 input logic [egcd_pkg::OPERAND_BITS-1:0] b);
        t_gcd_result                       r;
        logic [egcd_pkg::OPERAND_BITS-1:0] hi;
        logic [egcd_pkg::OPERAND_BITS-1:0] lo;
        logic [egcd_pkg::OPERAND_BITS-1:0] rem;
        r.both_zero = 1'b0;
        r.divisor   = '0;
        if (a == 0 && b == 0) begin
            r.both_zero = 1'b1;
        end else if (a == 0) begin
            r.divisor = b;
        end else if (b == 0) begin
            r.divisor = a;
        end else begin
            hi  = (a >= b) ? a : b;
            lo  = (a >= b) ? b : a;
            rem = hi % lo;
            while (rem != 0) begin
                hi  = lo;
                lo  = rem;
                rem = hi % lo;
            end
            r.divisor = lo;
        end
        return r;
    endfunction

    function automatic logic [egcd_pkg::OPERAND_BITS-1:0] random_operand(input int unsigned bits);
        logic [egcd_pkg::OPERAND_BITS-1:0] v;
        v = $urandom;
        if (bits < egcd_pkg::OPERAND_BITS) v = v & ((32'd1 << bits) - 1);
        return v;
    endfunction

    task automatic add_request(input logic [egcd_pkg::OPERAND_BITS-1:0] a,
                               input logic [egcd_pkg::OPERAND_BITS-1:0] b);
        t_gcd_request req;
        req.operand_a = a;
        req.operand_b = b;
        request_queue.push_back(req);
    endtask

    // request driver: holds an offered request until taken, idles in bursts
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || req_fired)) begin
            if (src_idle != 0) begin
                src_idle   <= src_idle - 1;
                i_s_tvalid <= 1'b0;
            end else if (request_queue.size() > TAIL_ITEMS && !src_rested
                         && $urandom_range(0, 3) == 0) begin
                src_idle   <= $urandom_range(0, 15);
                src_rested <= 1'b1;
                i_s_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                i_s_tdata  <= request_queue.pop_front();
                i_s_tvalid <= 1'b1;
                src_rested <= 1'b0;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result sink: stalls in bursts until the tail of the run
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (sink_hold != 0) begin
                sink_hold  <= sink_hold - 1;
                i_m_tready <= 1'b0;
            end else if (request_queue.size() > TAIL_ITEMS && $urandom_range(0, 19) == 0) begin
                sink_hold  <= $urandom_range(0, 15);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // monitor: results are checked before a request taken at the same edge is queued
    always @(posedge i_clk) begin
        req_fired <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (gcd_due.size() == 0) begin
                    $error("unexpected result: divisor %0d both_zero %0b", o_m_tdata, o_m_tuser);
                    fail_count++;
                end else begin
                    due_head = gcd_due.pop_front();
                    if (o_m_tdata !== due_head.divisor) begin
                        $error("divisor mismatch: expected %0d, actual %0d",
                               due_head.divisor, o_m_tdata);
                        fail_count++;
                    end
                    if (o_m_tuser !== due_head.both_zero) begin
                        $error("both_zero mismatch: expected %0b, actual %0b",
                               due_head.both_zero, o_m_tuser);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                gcd_due.push_back(expected_gcd(i_s_tdata[31:0], i_s_tdata[63:32]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [egcd_pkg::OPERAND_BITS-1:0] a;
        logic [egcd_pkg::OPERAND_BITS-1:0] b;
        logic [egcd_pkg::OPERAND_BITS-1:0] t;
        logic [egcd_pkg::OPERAND_BITS-1:0] g;
        int unsigned                       steps;

        // zero operands, extremes, equal values, worst-case fibonacci pair
        add_request(32'd0, 32'd0);
        add_request(32'd0, 32'd1);
        add_request(32'd1, 32'd0);
        add_request(32'd0, 32'hFFFF_FFFF);
        add_request(32'hFFFF_FFFF, 32'd0);
        add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(32'd1, 32'hFFFF_FFFF);
        add_request(32'hFFFF_FFFF, 32'd1);
        add_request(32'd1, 32'd1);
        add_request(32'd7, 32'd7);
        add_request(32'd12, 32'd18);
        add_request(32'd18, 32'd12);
        add_request(32'd2971215073, 32'd1836311903);
        add_request(32'd1836311903, 32'd2971215073);
        add_request(32'h8000_0000, 32'hC000_0000);
        add_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_request(32'hAAAA_AAAA, 32'h5555_5555);
        add_request(32'd17, 32'd4294967291);

        // mostly narrow operands to keep the euclid chains short
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                    a = random_operand($urandom_range(1, 20));
                    b = random_operand($urandom_range(1, 20));
                end
                11, 12, 13, 14: begin
                    g = $urandom_range(1, 65535);
                    a = g * $urandom_range(0, 32'hFFFF_FFFF / g);
                    b = g * $urandom_range(0, 32'hFFFF_FFFF / g);
                end
                15, 16: begin
                    a = $urandom;
                    b = $urandom;
                end
                17: begin
                    a = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
                    b = (a != 0 || $urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
                    if ($urandom_range(0, 1) == 0) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
                18: begin
                    // consecutive fibonacci numbers make the longest chains
                    a = 32'd1;
                    b = 32'd1;
                    steps = $urandom_range(1, 45);
                    for (int k = 0; k < steps; k++) begin
                        t = a + b;
                        b = a;
                        a = t;
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
                default: begin
                    a = random_operand($urandom_range(1, 32));
                    b = a;
                end
            endcase
            add_request(a, b);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (gcd_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
